// ===== design/msf_pkg.sv =====
package msf_pkg;

  localparam int SLOTS     = 16;
  localparam int BUF_BYTES = 64;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = SLOT_W + 1;
  localparam int LEN_W   = $clog2(BUF_BYTES + 1);
  localparam int DEPTH   = SLOTS * BUF_BYTES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Fixed field widths of the ports
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int MLEN_W  = 7;
  localparam int NUM_W   = 4;

  // Request queue between front and back; depth is a power of two
  localparam int JQ_DEPTH = 2;
  localparam int JQ_PTR_W = $clog2(JQ_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_COMMIT  = 2'd1,
    OP_POP     = 2'd2,
    OP_DISCARD = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_COMMIT  = 2'd0,
    KIND_READ    = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_STREAM
  } back_state_e;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One classified request, handed from front to back
  typedef struct packed {
    kind_e kind;
    logic  ok;
    len_t  len;
    logic  stream;
    slot_t slot;
    slot_t used;
    slot_t free;
  } job_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_inc = (s == SLOT_W'(SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

  function automatic addr_t byte_addr(slot_t s, len_t idx);
    byte_addr = addr_t'(ADDR_W'(s) * ADDR_W'(BUF_BYTES)) + addr_t'(idx);
  endfunction

endpackage

// ===== design/msf_ram.sv =====
module msf_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/msf_front.sv =====
module msf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [msf_pkg::OP_W-1:0]      op_i,
  input  logic [msf_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          hazard_i,
  output msf_pkg::slot_t                wslot_o,
  input  logic                          q_full_i,
  output logic                          job_valid_o,
  output msf_pkg::job_t                 job_o,
  output logic                          mem_we_o,
  output msf_pkg::addr_t                mem_waddr_o,
  output logic [msf_pkg::BYTE_W-1:0]    mem_wdata_o
);
  import msf_pkg::*;

  slot_t w_q, w_d, r_q, r_d;
  len_t  asm_q, asm_d;
  len_t  len_q [SLOTS];

  logic           accept;
  op_e            op;
  logic [CNT_W-1:0] diff;
  slot_t          used_now;
  slot_t          used_after;
  len_t           head_len;
  logic           len_we;

  assign op         = op_e'(op_i);
  assign in_ready_o = !q_full_i && !hazard_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wslot_o    = w_q;

  always_comb begin
    diff = CNT_W'(w_q) - CNT_W'(r_q);
    if (w_q < r_q) begin
      diff = diff + CNT_W'(SLOTS);
    end
    used_now = slot_t'(diff);
  end

  always_comb begin
    head_len = len_q[r_q];
    if (head_len > LEN_W'(BUF_BYTES)) begin
      head_len = LEN_W'(BUF_BYTES);
    end
  end

  assign mem_we_o    = accept && (op == OP_PUSH) && (asm_q < LEN_W'(BUF_BYTES));
  assign mem_waddr_o = byte_addr(w_q, asm_q);
  assign mem_wdata_o = data_byte_i;

  always_comb begin
    w_d         = w_q;
    r_d         = r_q;
    asm_d       = asm_q;
    len_we      = 1'b0;
    used_after  = used_now;
    job_valid_o = 1'b0;
    job_o       = '0;
    job_o.kind  = KIND_COMMIT;
    job_o.slot  = r_q;
    if (accept) begin
      case (op)
        OP_PUSH: begin
          if (asm_q < LEN_W'(BUF_BYTES)) begin
            asm_d = asm_q + 1'b1;
          end
        end
        OP_COMMIT: begin
          job_valid_o = 1'b1;
          asm_d       = '0;
          if (used_now != SLOT_W'(SLOTS - 1)) begin
            len_we     = 1'b1;
            w_d        = slot_inc(w_q);
            used_after = used_now + 1'b1;
            job_o.ok   = 1'b1;
            job_o.len  = asm_q;
          end
        end
        OP_POP, OP_DISCARD: begin
          job_valid_o = 1'b1;
          job_o.kind  = (op == OP_POP) ? KIND_READ : KIND_DISCARD;
          if (used_now != '0) begin
            r_d          = slot_inc(r_q);
            used_after   = used_now - 1'b1;
            job_o.ok     = 1'b1;
            job_o.len    = head_len;
            job_o.stream = (op == OP_POP) && (head_len != '0);
          end
        end
        default: begin
          job_valid_o = 1'b0;
        end
      endcase
    end
    job_o.used = used_after;
    job_o.free = slot_t'(SLOT_W'(SLOTS - 1) - used_after);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= '0;
      r_q   <= '0;
      asm_q <= '0;
    end else begin
      w_q   <= w_d;
      r_q   <= r_d;
      asm_q <= asm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_q[w_q] <= asm_q;
    end
  end

endmodule

// ===== design/msf_job_q.sv =====
module msf_job_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msf_pkg::job_t  push_job_i,
  output logic           full_o,
  output logic           head_valid_o,
  output msf_pkg::job_t  head_job_o,
  input  logic           pop_i,
  input  msf_pkg::slot_t wslot_i,
  output logic           hit_o
);
  import msf_pkg::*;

  job_t                 ent_q [JQ_DEPTH];
  logic [JQ_DEPTH-1:0]  occ_q, occ_d;
  logic [JQ_PTR_W-1:0]  wr_q, rd_q;

  assign full_o       = &occ_q;
  assign head_valid_o = occ_q[rd_q];
  assign head_job_o   = ent_q[rd_q];

  // Flag a queued read of the slot that pushes are about to overwrite
  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < JQ_DEPTH; i++) begin
      if (occ_q[i] && ent_q[i].stream && (ent_q[i].slot == wslot_i)) begin
        hit_o = 1'b1;
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (push_i) begin
      occ_d[wr_q] = 1'b1;
    end
    if (pop_i) begin
      occ_d[rd_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      occ_q <= occ_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/msf_back.sv =====
module msf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  msf_pkg::job_t                 job_i,
  output logic                          job_ready_o,
  input  msf_pkg::slot_t                wslot_i,
  output logic                          hit_o,
  output logic                          mem_re_o,
  output msf_pkg::addr_t                mem_raddr_o,
  input  logic [msf_pkg::BYTE_W-1:0]    mem_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [msf_pkg::KIND_W-1:0]    resp_kind_o,
  output logic                          ok_o,
  output logic [msf_pkg::MLEN_W-1:0]    msg_len_o,
  output logic [msf_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [msf_pkg::NUM_W-1:0]     used_slots_o,
  output logic [msf_pkg::NUM_W-1:0]     free_slots_o
);
  import msf_pkg::*;

  back_state_e state_q, state_d;
  job_t        cur_q;
  len_t        idx_q;

  logic  out_valid_q;
  job_t  out_job_q;
  logic  out_bvalid_q;
  logic  out_last_q;

  logic  can_load;
  logic  load;
  job_t  ld_job;
  logic  ld_bvalid;
  logic  ld_last;
  slot_t rd_slot;
  len_t  rd_idx;

  assign can_load = !out_valid_q || out_ready_i;
  assign hit_o    = (state_q == BK_STREAM) && (cur_q.slot == wslot_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i && can_load && job_i.stream && (job_i.len > LEN_W'(1))) begin
          state_d = BK_STREAM;
        end
      end
      BK_STREAM: begin
        if (can_load && (idx_q == cur_q.len - LEN_W'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    job_ready_o = 1'b0;
    load        = 1'b0;
    ld_job      = job_i;
    ld_bvalid   = 1'b0;
    ld_last     = 1'b1;
    rd_slot     = job_i.slot;
    rd_idx      = '0;
    mem_re_o    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        job_ready_o = can_load;
        if (job_valid_i && can_load) begin
          load      = 1'b1;
          ld_bvalid = job_i.stream;
          ld_last   = !job_i.stream || (job_i.len == LEN_W'(1));
          mem_re_o  = job_i.stream;
        end
      end
      BK_STREAM: begin
        ld_job  = cur_q;
        rd_slot = cur_q.slot;
        rd_idx  = idx_q;
        if (can_load) begin
          load      = 1'b1;
          ld_bvalid = 1'b1;
          ld_last   = (idx_q == cur_q.len - LEN_W'(1));
          mem_re_o  = 1'b1;
        end
      end
      default: begin
        job_ready_o = 1'b0;
      end
    endcase
    mem_raddr_o = byte_addr(rd_slot, rd_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_job_q    <= ld_job;
      out_bvalid_q <= ld_bvalid;
      out_last_q   <= ld_last;
    end
    if ((state_q == BK_IDLE) && job_valid_i && can_load) begin
      cur_q <= job_i;
      idx_q <= LEN_W'(1);
    end else if ((state_q == BK_STREAM) && can_load) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign resp_kind_o  = out_job_q.kind;
  assign ok_o         = out_job_q.ok;
  assign msg_len_o    = MLEN_W'(out_job_q.len);
  assign out_byte_o   = out_bvalid_q ? mem_rdata_i : '0;
  assign byte_valid_o = out_bvalid_q;
  assign last_o       = out_last_q;
  assign used_slots_o = NUM_W'(out_job_q.used);
  assign free_slots_o = NUM_W'(out_job_q.free);

endmodule

// ===== design/message_slot_fifo.sv =====
// A push request yields no result; commit, pop and discard results pass through the
//   request queue and the back end's output register. A pop holds the back end to its last byte.
// Throughput: one request per cycle while in_ready_o is high; a pop streams one byte
//   per cycle, as out_ready_i allows, through the slot memory's single read port.
// Reset (rst_ni low, asynchronous) empties the queue and the assembly count;
//   slot bytes and lengths are left as they are and are read only after written.
module message_slot_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [msf_pkg::OP_W-1:0]      op_i,
  input  logic [msf_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [msf_pkg::KIND_W-1:0]    resp_kind_o,
  output logic                          ok_o,
  output logic [msf_pkg::MLEN_W-1:0]    msg_len_o,
  output logic [msf_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          last_o,
  output logic [msf_pkg::NUM_W-1:0]     used_slots_o,
  output logic [msf_pkg::NUM_W-1:0]     free_slots_o
);
  import msf_pkg::*;

  // Front side: classified requests and byte writes
  logic  job_valid;
  job_t  job;
  logic  q_full;
  slot_t wslot;
  logic  mem_we;
  addr_t mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;

  // Back side: queue head and memory reads
  logic  head_valid;
  job_t  head_job;
  logic  head_ready;
  logic  mem_re;
  addr_t mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Hold all requests, not only pushes, while the write slot still has bytes waiting to stream out
  logic q_hit, back_hit, hazard;
  assign hazard = q_hit || back_hit;

  msf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .hazard_i    (hazard),
    .wslot_o     (wslot),
    .q_full_i    (q_full),
    .job_valid_o (job_valid),
    .job_o       (job),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // Short request queue: lets the front keep taking pushes while a pop streams
  msf_job_q u_job_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_job_i   (job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (head_valid && head_ready),
    .wslot_i      (wslot),
    .hit_o        (q_hit)
  );

  msf_ram #(
    .Depth (DEPTH),
    .Width (BYTE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Back end: expand each request into results, one per cycle while out_ready_i allows
  msf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (head_valid),
    .job_i        (head_job),
    .job_ready_o  (head_ready),
    .wslot_i      (wslot),
    .hit_o        (back_hit),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .resp_kind_o  (resp_kind_o),
    .ok_o         (ok_o),
    .msg_len_o    (msg_len_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .used_slots_o (used_slots_o),
    .free_slots_o (free_slots_o)
  );

endmodule

// ===== design/msf_checker.sv =====
module msf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [msf_pkg::KIND_W-1:0]    resp_kind_o,
  input logic                          ok_o,
  input logic [msf_pkg::MLEN_W-1:0]    msg_len_o,
  input logic [msf_pkg::BYTE_W-1:0]    out_byte_o,
  input logic                          byte_valid_o,
  input logic                          last_o,
  input logic [msf_pkg::NUM_W-1:0]     used_slots_o,
  input logic [msf_pkg::NUM_W-1:0]     free_slots_o
);
  import msf_pkg::*;

  logic [NUM_W-1:0] slot_sum;
  assign slot_sum = used_slots_o + free_slots_o;

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_o) && $stable(msg_len_o) && $stable(resp_kind_o))
    else $error("result changed while stalled");

  a_slot_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_sum == NUM_W'(SLOTS - 1))
    else $error("used and free slots do not add up");

  a_byte_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> resp_kind_o == KIND_READ && ok_o
      && msg_len_o != '0)
    else $error("data byte outside a successful read");

  a_fail_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> msg_len_o == '0 && last_o && !byte_valid_o)
    else $error("failed request carries a length or more results");

  a_nondata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_o && out_byte_o == '0)
    else $error("non-data result not marked last");

endmodule

bind message_slot_fifo msf_checker u_msf_checker (.*);

// ===== verif/tb_message_slot_fifo.sv =====
module tb_message_slot_fifo;
  import msf_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 150;
  localparam int TAIL_CYCLES  = 16;

  // One reply as it appears on the output ports
  typedef struct packed {
    kind_e               kind;
    logic                ok;
    logic [MLEN_W-1:0]   len;
    logic [BYTE_W-1:0]   data;
    logic                bv;
    logic                last;
    logic [NUM_W-1:0]    used;
    logic [NUM_W-1:0]    free;
  } reply_t;

  // One line of the directed table; data steps by 37 per repeat
  typedef struct {
    op_e               op;
    logic [BYTE_W-1:0] data;
    int                reps;
    bit                fixed;
    reply_t            want;
  } step_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [OP_W-1:0]   op_i        = OP_PUSH;
  logic [BYTE_W-1:0] data_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [KIND_W-1:0] resp_kind_o;
  logic              ok_o;
  logic [MLEN_W-1:0] msg_len_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic              byte_valid_o;
  logic              last_o;
  logic [NUM_W-1:0]  used_slots_o;
  logic [NUM_W-1:0]  free_slots_o;

  message_slot_fifo u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .resp_kind_o  (resp_kind_o),
    .ok_o         (ok_o),
    .msg_len_o    (msg_len_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_o       (last_o),
    .used_slots_o (used_slots_o),
    .free_slots_o (free_slots_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the slot store
  logic [BYTE_W-1:0] slot_mem [SLOTS][BUF_BYTES];
  int                slot_len [SLOTS];
  int                wr_slot   = 0;
  int                rd_slot   = 0;
  int                asm_count = 0;

  reply_t pending_replies[$];

  int mismatches     = 0;
  int replies_seen   = 0;
  int requests_sent  = 0;
  int full_rejects   = 0;
  int dropped_bytes  = 0;
  int peak_held      = 0;
  int cycles         = 0;
  int burst_left     = 0;

  function automatic int held_count();
    return (wr_slot + SLOTS - rd_slot) % SLOTS;
  endfunction

  function automatic reply_t fixed_reply(kind_e kind, logic ok, int len, int used, int free);
    reply_t r;
    r.kind = kind;
    r.ok   = ok;
    r.len  = MLEN_W'(len);
    r.data = '0;
    r.bv   = 1'b0;
    r.last = 1'b1;
    r.used = NUM_W'(used);
    r.free = NUM_W'(free);
    return r;
  endfunction

  function automatic step_row_t row(op_e op, logic [BYTE_W-1:0] data, int reps, bit fixed,
                                    reply_t want);
    step_row_t s;
    s.op    = op;
    s.data  = data;
    s.reps  = reps;
    s.fixed = fixed;
    s.want  = want;
    return s;
  endfunction

  // Queue one expected reply; the counts reflect the state after this request
  task automatic post_reply(kind_e kind, logic ok, int len, logic [BYTE_W-1:0] data,
                            logic bv, logic last);
    reply_t r;
    r.kind = kind;
    r.ok   = ok;
    r.len  = MLEN_W'(len);
    r.data = data;
    r.bv   = bv;
    r.last = last;
    r.used = NUM_W'(held_count());
    r.free = NUM_W'(SLOTS - 1 - held_count());
    pending_replies.push_back(r);
  endtask

  // Advance the shadow queue by one accepted request
  task automatic apply_request(op_e op, logic [BYTE_W-1:0] d);
    int w;
    int r;
    int len;
    int i;
    w = wr_slot;
    r = rd_slot;
    case (op)
      OP_PUSH: begin
        if (asm_count < BUF_BYTES) begin
          slot_mem[w][asm_count] = d;
          asm_count++;
        end else begin
          dropped_bytes++;
        end
      end
      OP_COMMIT: begin
        len       = asm_count;
        asm_count = 0;
        if (held_count() < SLOTS - 1) begin
          slot_len[w] = len;
          wr_slot     = (w + 1) % SLOTS;
          post_reply(KIND_COMMIT, 1'b1, len, '0, 1'b0, 1'b1);
        end else begin
          full_rejects++;
          post_reply(KIND_COMMIT, 1'b0, 0, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        if (held_count() == 0) begin
          post_reply((op == OP_POP) ? KIND_READ : KIND_DISCARD, 1'b0, 0, '0, 1'b0, 1'b1);
        end else begin
          len     = slot_len[r];
          rd_slot = (r + 1) % SLOTS;
          if (op == OP_DISCARD) begin
            post_reply(KIND_DISCARD, 1'b1, len, '0, 1'b0, 1'b1);
          end else if (len == 0) begin
            post_reply(KIND_READ, 1'b1, 0, '0, 1'b0, 1'b1);
          end else begin
            for (i = 0; i < len; i++) begin
              post_reply(KIND_READ, 1'b1, len, slot_mem[r][i], 1'b1, i == len - 1);
            end
          end
        end
      end
    endcase
    if (held_count() > peak_held) peak_held = held_count();
  endtask

  // Hand one request to the block; idle between bursts first
  task automatic send(op_e op, logic [BYTE_W-1:0] d, bit fixed, reply_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
    apply_request(op, d);
    if (fixed) begin
      void'(pending_replies.pop_back());
      pending_replies.push_back(want);
    end
  endtask

  task automatic send_random(op_e op);
    send(op, BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Hold off the sender until every expected reply is back
  task automatic drain_wait();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: switch at random among three stall styles: always ready, randomly ready, alternating runs
  int rx_mode = 0;
  int rx_tick = 0;
  int rx_run  = 0;
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          out_ready_i <= !out_ready_i;
          rx_run = out_ready_i ? $urandom_range(1, 8) : $urandom_range(1, 4);
        end else begin
          rx_run--;
        end
      end
    endcase
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none actual kind %0d len %0d byte %0d",
                 $time, resp_kind_o, msg_len_o, out_byte_o);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("resp_kind",  want.kind, resp_kind_o);
        check_field("ok",         want.ok,   ok_o);
        check_field("msg_len",    want.len,  msg_len_o);
        check_field("out_byte",   want.data, out_byte_o);
        check_field("byte_valid", want.bv,   byte_valid_o);
        check_field("last",       want.last, last_o);
        check_field("used_slots", want.used, used_slots_o);
        check_field("free_slots", want.free, free_slots_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles,
               pending_replies.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  step_row_t dir_table[$];

  initial begin : stimulus
    int k;
    int n;
    int sel;
    int dir_count;
    bit mid_drained;
    mid_drained = 1'b0;

    // Typed rows: empty queue answers, empty message, truncated message, full queue
    dir_table.push_back(row(OP_POP,     8'h00, 1,  1, fixed_reply(KIND_READ,    0, 0,  0,  15)));
    dir_table.push_back(row(OP_DISCARD, 8'hFF, 1,  1, fixed_reply(KIND_DISCARD, 0, 0,  0,  15)));
    dir_table.push_back(row(OP_COMMIT,  8'h00, 1,  1, fixed_reply(KIND_COMMIT,  1, 0,  1,  14)));
    dir_table.push_back(row(OP_POP,     8'h00, 1,  1, fixed_reply(KIND_READ,    1, 0,  0,  15)));
    dir_table.push_back(row(OP_PUSH,    8'h00, 1,  0, '0));
    dir_table.push_back(row(OP_PUSH,    8'hFF, 1,  0, '0));
    dir_table.push_back(row(OP_PUSH,    8'h5A, 1,  0, '0));
    dir_table.push_back(row(OP_COMMIT,  8'hFF, 1,  0, '0));
    dir_table.push_back(row(OP_POP,     8'hFF, 1,  0, '0));
    dir_table.push_back(row(OP_PUSH,    8'h01, 70, 0, '0));
    dir_table.push_back(row(OP_COMMIT,  8'h00, 1,  1, fixed_reply(KIND_COMMIT,  1, 64, 1, 14)));
    dir_table.push_back(row(OP_POP,     8'h00, 1,  0, '0));
    dir_table.push_back(row(OP_PUSH,    8'h81, 3,  0, '0));
    dir_table.push_back(row(OP_COMMIT,  8'h00, 15, 0, '0));
    dir_table.push_back(row(OP_COMMIT,  8'h00, 1,  1, fixed_reply(KIND_COMMIT,  0, 0,  15, 0)));
    dir_table.push_back(row(OP_PUSH,    8'h33, 1,  0, '0));
    dir_table.push_back(row(OP_COMMIT,  8'h00, 1,  1, fixed_reply(KIND_COMMIT,  0, 0,  15, 0)));
    dir_table.push_back(row(OP_DISCARD, 8'h00, 1,  0, '0));
    dir_table.push_back(row(OP_COMMIT,  8'h00, 1,  0, '0));
    dir_table.push_back(row(OP_POP,     8'h00, 15, 0, '0));
    dir_table.push_back(row(OP_POP,     8'h00, 1,  1, fixed_reply(KIND_READ,    0, 0,  0,  15)));
    dir_table.push_back(row(OP_DISCARD, 8'h00, 1,  1, fixed_reply(KIND_DISCARD, 0, 0,  0,  15)));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      for (k = 0; k < dir_table[i].reps; k++) begin
        send(dir_table[i].op, dir_table[i].data + BYTE_W'(k * 37), dir_table[i].fixed,
             dir_table[i].want);
      end
    end
    drain_wait();
    dir_count = requests_sent;

    // Mostly well-formed messages, with pops, discards, commit bursts and noise
    while (requests_sent < dir_count + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 6);
        repeat (n) send_random(OP_PUSH);
        send_random(OP_COMMIT);
      end else if (sel < 68) begin
        send_random(OP_POP);
      end else if (sel < 80) begin
        send_random(OP_DISCARD);
      end else if (sel < 90) begin
        send_random(op_e'(OP_W'($urandom_range(0, 3))));
      end else begin
        repeat ($urandom_range(4, 16)) send_random(OP_COMMIT);
      end
      if (!mid_drained && requests_sent > dir_count + RANDOM_ITEMS / 2) begin
        mid_drained = 1'b1;
        drain_wait();
      end
    end

    drain_wait();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, pending_replies.size());
      mismatches++;
    end

    $display("Covered %0d requests and %0d replies; %0d commits rejected on a full queue,",
             requests_sent, replies_seen, full_rejects);
    $display("%0d bytes dropped past the slot end, up to %0d messages held at once.",
             dropped_bytes, peak_held);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/msf_pkg.sv
design/msf_ram.sv
design/msf_front.sv
design/msf_job_q.sv
design/msf_back.sv
design/message_slot_fifo.sv
design/msf_checker.sv
verif/tb_message_slot_fifo.sv
